// ----- rtl/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// plc_pkg : shared types and constants for the phone line call controller
// Line states, tone and modem command codes, event codes and the
// command/status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   // field widths fixed by the transaction format
   localparam int CNT_W   = 5;
   localparam int TIMER_W = 16;
   localparam int DIGIT_W = 4;
   localparam int TONE_W  = 3;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [TIMER_W-1:0] INTER_DIGIT_RESET = 16'd4000;
   localparam logic [TIMER_W-1:0] HANGUP_HOLD_RESET = 16'd500;
   localparam logic [CNT_W-1:0]   MIN_DIGITS_RESET  = 5'd3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_INTER_DIGIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HANGUP_HOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIGITS  = 2'd2;

   // pound key from the dtmf detector
   localparam logic [DIGIT_W-1:0] POUND_CODE = 4'd12;

   // tone codes
   localparam logic [TONE_W-1:0] T_NONE       = 3'd0;
   localparam logic [TONE_W-1:0] T_DIAL       = 3'd1;
   localparam logic [TONE_W-1:0] T_RINGBACK   = 3'd2;
   localparam logic [TONE_W-1:0] T_BUSY       = 3'd3;
   localparam logic [TONE_W-1:0] T_CONGESTION = 3'd4;

   // modem command codes
   localparam logic [CMD_W-1:0] C_NONE   = 2'd0;
   localparam logic [CMD_W-1:0] C_ANSWER = 2'd1;
   localparam logic [CMD_W-1:0] C_HANGUP = 2'd2;
   localparam logic [CMD_W-1:0] C_DIAL   = 2'd3;

   // modem event codes, the last one carries no meaning
   localparam logic [1:0] ME_RING      = 2'd0;
   localparam logic [1:0] ME_ENDED     = 2'd1;
   localparam logic [1:0] ME_CONNECTED = 2'd2;
   localparam logic [1:0] ME_RESERVED  = 2'd3;

   typedef enum logic [1:0] {
      K_TICK  = 2'd0,
      K_HOOK  = 2'd1,
      K_DIGIT = 2'd2,
      K_MODEM = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      LS_IDLE     = 3'd0,
      LS_RINGING  = 3'd1,
      LS_INCALL   = 3'd2,
      LS_DIALTONE = 3'd3,
      LS_DIALING  = 3'd4,
      LS_OUTCALL  = 3'd5,
      LS_HANGUP   = 3'd6
   } line_state_type;

   typedef enum logic [1:0] {
      CS_WAIT,
      CS_EVAL,
      CS_DIAL_RD,
      CS_DIAL_OUT
   } ctrl_state_type;

   // sequencer to datapath
   typedef struct packed {
      logic capture;
      logic apply;
      logic emit_single;
      logic emit_digit;
   } ctrl_cmd_type;

   // datapath to sequencer
   typedef struct packed {
      logic out_free;
      logic dial_go;
      logic dial_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/plc_ctrl.sv -----
// ----------------------------------------------------------------------------
// plc_ctrl : transaction sequencer
// Takes one input transaction, has the datapath evaluate it once and then
// walks the stored digits one result at a time when a dial goes out.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  plc_pkg::dp_status_type      status,
   output plc_pkg::ctrl_cmd_type       cmd
);
   import plc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.capture     = 1'b0;
      cmd.apply       = 1'b0;
      cmd.emit_single = 1'b0;
      cmd.emit_digit  = 1'b0;
      unique case (state_ff)
         CS_WAIT: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = CS_EVAL;
            end
         end
         CS_EVAL: begin
            if (status.out_free) begin
               cmd.apply = 1'b1;
               if (status.dial_go) begin
                  state_in = CS_DIAL_RD;
               end else begin
                  cmd.emit_single = 1'b1;
                  state_in        = CS_WAIT;
               end
            end
         end
         CS_DIAL_RD: begin
            state_in = CS_DIAL_OUT;
         end
         CS_DIAL_OUT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in = status.dial_last ? CS_WAIT : CS_DIAL_RD;
            end
         end
         default: begin
            state_in = CS_WAIT;
         end
      endcase
   end

   assign req_stall = (state_ff != CS_WAIT);

endmodule

`default_nettype wire

// ----- rtl/plc_datapath.sv -----
// ----------------------------------------------------------------------------
// plc_datapath : line state, timers, digit store and result register
// Holds the architectural state of the line, evaluates one captured
// transaction per apply command and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_datapath #(
   parameter int DIGIT_STORE_DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  plc_pkg::ctrl_cmd_type              cmd,
   output plc_pkg::dp_status_type             status,
   input  wire logic [1:0]                    req_kind,
   input  wire logic                          req_hook_level,
   input  wire logic [plc_pkg::DIGIT_W-1:0]   req_digit_code,
   input  wire logic [1:0]                    req_modem_event,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [plc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [plc_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ring_active,
   output logic [plc_pkg::TONE_W-1:0]         rsp_tone_select,
   output logic [plc_pkg::CMD_W-1:0]          rsp_modem_command,
   output logic [plc_pkg::DIGIT_W-1:0]        rsp_dial_digit,
   output logic [2:0]                         rsp_line_state,
   output logic                               rsp_last
);
   import plc_pkg::*;

   localparam int AW = $clog2(DIGIT_STORE_DEPTH);
   localparam int DIAL_CAP = (DIGIT_STORE_DEPTH - 1 < 31) ? DIGIT_STORE_DEPTH - 1 : 31;

   // configuration registers
   logic [TIMER_W-1:0] inter_digit_ff;
   logic [TIMER_W-1:0] hangup_hold_ff;
   logic [CNT_W-1:0]   min_digits_ff;

   // captured transaction
   kind_type           item_kind_ff;
   logic               item_hook_ff;
   logic [DIGIT_W-1:0] item_digit_ff;
   logic [1:0]         item_event_ff;

   // line state
   line_state_type     line_state_ff, line_state_in;
   logic               prev_hook_ff, prev_hook_in;
   logic               ring_ff, ring_in;
   logic [TONE_W-1:0]  tone_ff, tone_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIMER_W-1:0] since_ff, since_in;
   logic [TIMER_W-1:0] held_ff, held_in;

   // digit store and dial walk
   logic [DIGIT_W-1:0] store_mem [DIGIT_STORE_DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]   dial_idx_ff;
   logic               wr_en;
   logic [CNT_W-1:0]   wr_pos;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_ring_ff;
   logic [TONE_W-1:0]  rsp_tone_ff;
   logic [CMD_W-1:0]   rsp_cmd_ff;
   logic [DIGIT_W-1:0] rsp_digit_ff;
   line_state_type     rsp_state_ff;
   logic               rsp_last_ff;

   logic [TIMER_W-1:0] since_sat;
   logic [TIMER_W-1:0] held_sat;
   logic [CMD_W-1:0]   cmd_code;
   logic               do_dial;
   logic               dial_short;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inter_digit_ff <= INTER_DIGIT_RESET;
         hangup_hold_ff <= HANGUP_HOLD_RESET;
         min_digits_ff  <= MIN_DIGITS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_INTER_DIGIT) begin
            inter_digit_ff <= csr_data;
         end
         if (csr_index == CSR_HANGUP_HOLD) begin
            hangup_hold_ff <= csr_data;
         end
         if (csr_index == CSR_MIN_DIGITS) begin
            min_digits_ff <= csr_data[CNT_W-1:0];
         end
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_kind_ff  <= kind_type'(req_kind);
         item_hook_ff  <= req_hook_level;
         item_digit_ff <= req_digit_code;
         item_event_ff <= req_modem_event;
      end
   end

   // saturating millisecond timers
   assign since_sat = (since_ff == '1) ? since_ff : since_ff + 1'b1;
   assign held_sat  = (held_ff == '1) ? held_ff : held_ff + 1'b1;

   // event evaluation
   always_comb begin
      line_state_in = line_state_ff;
      prev_hook_in  = prev_hook_ff;
      ring_in       = ring_ff;
      tone_in       = tone_ff;
      count_in      = count_ff;
      since_in      = since_ff;
      held_in       = held_ff;
      cmd_code      = C_NONE;
      do_dial       = 1'b0;
      wr_en         = 1'b0;
      wr_pos        = '0;
      unique case (item_kind_ff)
         K_TICK: begin
            if (line_state_ff == LS_DIALING) begin
               since_in = since_sat;
               if (since_sat >= inter_digit_ff) begin
                  do_dial = 1'b1;
               end
            end else if (line_state_ff == LS_HANGUP) begin
               held_in = held_sat;
               if (held_sat >= hangup_hold_ff) begin
                  tone_in       = T_NONE;
                  line_state_in = LS_IDLE;
                  held_in       = '0;
               end
            end else begin
               held_in = '0;
            end
         end
         K_HOOK: begin
            if (item_hook_ff != prev_hook_ff) begin
               prev_hook_in = item_hook_ff;
               if (item_hook_ff) begin
                  // off hook
                  if (line_state_ff == LS_IDLE) begin
                     tone_in       = T_DIAL;
                     count_in      = '0;
                     line_state_in = LS_DIALTONE;
                  end else if (line_state_ff == LS_RINGING) begin
                     ring_in       = 1'b0;
                     cmd_code      = C_ANSWER;
                     tone_in       = T_NONE;
                     line_state_in = LS_INCALL;
                  end
               end else begin
                  // on hook
                  if (line_state_ff == LS_INCALL || line_state_ff == LS_OUTCALL) begin
                     cmd_code      = C_HANGUP;
                     tone_in       = T_NONE;
                     line_state_in = LS_HANGUP;
                  end else if (line_state_ff == LS_DIALTONE ||
                               line_state_ff == LS_DIALING) begin
                     cmd_code      = C_HANGUP;
                     tone_in       = T_NONE;
                     line_state_in = LS_IDLE;
                  end else if (line_state_ff == LS_HANGUP) begin
                     tone_in       = T_NONE;
                     line_state_in = LS_IDLE;
                  end
               end
            end
         end
         K_DIGIT: begin
            if (line_state_ff == LS_DIALTONE) begin
               tone_in       = T_NONE;
               wr_en         = 1'b1;
               wr_pos        = '0;
               count_in      = CNT_W'(1);
               since_in      = '0;
               line_state_in = LS_DIALING;
            end else if (line_state_ff == LS_DIALING) begin
               if (item_digit_ff == POUND_CODE) begin
                  do_dial = 1'b1;
               end else if (count_ff < CNT_W'(DIAL_CAP)) begin
                  wr_en    = 1'b1;
                  wr_pos   = count_ff;
                  count_in = count_ff + 1'b1;
                  since_in = '0;
               end
            end
         end
         K_MODEM: begin
            unique case (item_event_ff)
               ME_RING: begin
                  if (line_state_ff == LS_IDLE) begin
                     ring_in       = 1'b1;
                     line_state_in = LS_RINGING;
                  end
               end
               ME_ENDED: begin
                  if (line_state_ff == LS_RINGING) begin
                     ring_in       = 1'b0;
                     line_state_in = LS_IDLE;
                  end else if (line_state_ff == LS_INCALL ||
                               line_state_ff == LS_OUTCALL) begin
                     tone_in       = T_BUSY;
                     line_state_in = LS_HANGUP;
                  end else if (line_state_ff == LS_DIALING) begin
                     tone_in       = T_CONGESTION;
                     line_state_in = LS_HANGUP;
                  end else begin
                     line_state_in = LS_IDLE;
                  end
               end
               ME_CONNECTED: begin
                  if (line_state_ff == LS_OUTCALL) begin
                     tone_in = T_NONE;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // dial outcome
      dial_short = (count_ff == '0) || (count_ff < min_digits_ff);
      if (do_dial) begin
         if (dial_short) begin
            tone_in       = T_CONGESTION;
            line_state_in = LS_HANGUP;
         end else begin
            tone_in       = T_RINGBACK;
            line_state_in = LS_OUTCALL;
         end
      end

      // hold timer restarts on every entry into hangup
      if (line_state_in == LS_HANGUP && line_state_ff != LS_HANGUP) begin
         held_in = '0;
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_state_ff <= LS_IDLE;
         prev_hook_ff  <= 1'b0;
         ring_ff       <= 1'b0;
         tone_ff       <= T_NONE;
         count_ff      <= '0;
         since_ff      <= '0;
         held_ff       <= '0;
      end else if (cmd.apply) begin
         line_state_ff <= line_state_in;
         prev_hook_ff  <= prev_hook_in;
         ring_ff       <= ring_in;
         tone_ff       <= tone_in;
         count_ff      <= count_in;
         since_ff      <= since_in;
         held_ff       <= held_in;
      end
   end

   // digit store, registered read at the walk index
   always_ff @(posedge clock) begin
      if (cmd.apply && wr_en) begin
         store_mem[AW'(wr_pos)] <= item_digit_ff;
      end
      rd_data_ff <= store_mem[AW'(dial_idx_ff)];
   end

   // dial walk index
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         dial_idx_ff <= '0;
      end else if (cmd.emit_digit) begin
         dial_idx_ff <= dial_idx_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_single || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single) begin
         rsp_ring_ff  <= ring_in;
         rsp_tone_ff  <= tone_in;
         rsp_cmd_ff   <= cmd_code;
         rsp_digit_ff <= '0;
         rsp_state_ff <= line_state_in;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit_digit) begin
         rsp_ring_ff  <= ring_ff;
         rsp_tone_ff  <= tone_ff;
         rsp_cmd_ff   <= C_DIAL;
         rsp_digit_ff <= rd_data_ff;
         rsp_state_ff <= line_state_ff;
         rsp_last_ff  <= status.dial_last;
      end
   end

   // status back to the sequencer
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.dial_go   = do_dial && !dial_short;
   assign status.dial_last = ((dial_idx_ff + 1'b1) == count_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ring_active   = rsp_ring_ff;
   assign rsp_tone_select   = rsp_tone_ff;
   assign rsp_modem_command = rsp_cmd_ff;
   assign rsp_dial_digit    = rsp_digit_ff;
   assign rsp_line_state    = rsp_state_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/phone_line_call_control_fsm.sv -----
// Call controller for one analog phone line. Each request transaction is a
// millisecond tick, a hook sample, a DTMF digit or a modem event; each one
// gives a single response (last set), except a dial, triggered by the pound
// key or the inter-digit timeout with enough stored digits, which gives one
// response per stored digit with last on the final one. A request is
// captured and then evaluated, and the next one is not accepted until it
// is done; a dial then walks the digit store through its registered read,
// one digit per read and emit pair. A stalled response register holds
// the sequencer until it drains. Configuration is taken at any time on the
// csr port and must only change while no transaction is in flight.
// ----------------------------------------------------------------------------
// phone_line_call_control_fsm : top level
// Joins the transaction sequencer and the line datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module phone_line_call_control_fsm #(
   parameter int DIGIT_STORE_DEPTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_kind,
   input  wire logic                           req_hook_level,
   input  wire logic [plc_pkg::DIGIT_W-1:0]    req_digit_code,
   input  wire logic [1:0]                     req_modem_event,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_ring_active,
   output logic [plc_pkg::TONE_W-1:0]          rsp_tone_select,
   output logic [plc_pkg::CMD_W-1:0]           rsp_modem_command,
   output logic [plc_pkg::DIGIT_W-1:0]         rsp_dial_digit,
   output logic [2:0]                          rsp_line_state,
   output logic                                rsp_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [plc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [plc_pkg::CSR_DATA_W-1:0] csr_data
);
   import plc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // registers accept a write every cycle
   assign csr_ready = 1'b1;

   // transaction sequencer
   plc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // line datapath
   plc_datapath #(
      .DIGIT_STORE_DEPTH (DIGIT_STORE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_hook_level    (req_hook_level),
      .req_digit_code    (req_digit_code),
      .req_modem_event   (req_modem_event),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ring_active   (rsp_ring_active),
      .rsp_tone_select   (rsp_tone_select),
      .rsp_modem_command (rsp_modem_command),
      .rsp_dial_digit    (rsp_dial_digit),
      .rsp_line_state    (rsp_line_state),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/plc_checker.sv -----
// ----------------------------------------------------------------------------
// plc_checker : port level checks for the call controller
// Watches the response channel and the meaning of the reported commands.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic                           rsp_ring_active,
   input wire logic [plc_pkg::TONE_W-1:0]     rsp_tone_select,
   input wire logic [plc_pkg::CMD_W-1:0]      rsp_modem_command,
   input wire logic [plc_pkg::DIGIT_W-1:0]    rsp_dial_digit,
   input wire logic [2:0]                     rsp_line_state,
   input wire logic                           rsp_last
);
   import plc_pkg::*;

   // an accepted request holds the input off while it is evaluated
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on two consecutive cycles");

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_dial_digit) && $stable(rsp_last)
         && $stable(rsp_modem_command) && $stable(rsp_line_state))
      else $error("response payload changed while stalled");

   // dialled digits only go out in an outgoing call with ringback
   a_dial_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modem_command == C_DIAL |->
         rsp_line_state == LS_OUTCALL && rsp_tone_select == T_RINGBACK)
      else $error("dial digit outside an outgoing call");

   // answering puts the line in call with the ringer stopped
   a_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modem_command == C_ANSWER |->
         rsp_line_state == LS_INCALL && !rsp_ring_active && rsp_last)
      else $error("answer with wrong line state");

endmodule

bind phone_line_call_control_fsm plc_checker u_plc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_ring_active   (rsp_ring_active),
   .rsp_tone_select   (rsp_tone_select),
   .rsp_modem_command (rsp_modem_command),
   .rsp_dial_digit    (rsp_dial_digit),
   .rsp_line_state    (rsp_line_state),
   .rsp_last          (rsp_last)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the phone line call controller
// Drives ticks, hook samples, DTMF digits and modem events through the
// valid/stall request channel, predicts every response transaction with a
// shadow of the line state held in a scoreboard class and compares each
// response field by field. Register settings change between phases while
// the block is idle; both channels see random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_top;
   import plc_pkg::*;

   localparam int STORE_DEPTH      = 32;
   localparam int DIAL_CAPACITY    = (STORE_DEPTH - 1 < 31) ? STORE_DEPTH - 1 : 31;
   localparam int PHASES           = 5;
   localparam int PHASE_ITEMS      = 75;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 4000000;

   // one response transaction as seen on the rsp_ ports
   typedef struct packed {
      logic       ring;
      logic [2:0] tone;
      logic [1:0] cmd;
      logic [3:0] digit;
      logic [2:0] state;
      logic       last;
   } line_report_type;

   // shadow of the call controller plus the queue of responses it owes
   class line_scoreboard;
      logic [15:0]     digit_timeout_ms;
      logic [15:0]     hold_ms;
      logic [4:0]      min_digits;
      line_state_type  state;
      logic            hook_prev;
      logic            ringer;
      logic [2:0]      tone;
      logic [3:0]      dialled[DIAL_CAPACITY];
      int unsigned     dialled_count;
      logic [15:0]     idle_ms;
      logic [15:0]     hangup_ms;
      line_report_type owed[$];
      int              mismatches;

      function new();
         digit_timeout_ms = INTER_DIGIT_RESET;
         hold_ms = HANGUP_HOLD_RESET;
         min_digits = MIN_DIGITS_RESET;
         state = LS_IDLE;
         hook_prev = 1'b0;
         ringer = 1'b0;
         tone = T_NONE;
         dialled_count = 0;
         idle_ms = '0;
         hangup_ms = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
         case (idx)
            CSR_INTER_DIGIT: digit_timeout_ms = data;
            CSR_HANGUP_HOLD: hold_ms = data;
            CSR_MIN_DIGITS:  min_digits = data[4:0];
            default: ;
         endcase
      endfunction

      // hangup timer restarts on every fresh entry into hangup
      function void enter(line_state_type s);
         if (s == LS_HANGUP && state != LS_HANGUP) hangup_ms = '0;
         state = s;
      endfunction

      function void owe(logic [1:0] cmd, logic [3:0] dig, logic last);
         line_report_type r;
         r.ring = ringer;
         r.tone = tone;
         r.cmd = cmd;
         r.digit = dig;
         r.state = state;
         r.last = last;
         owed.push_back(r);
      endfunction

      // congestion on too few digits, else one dial response per digit
      function void start_dial();
         int unsigned i;
         if (dialled_count == 0 || dialled_count < min_digits) begin
            tone = T_CONGESTION;
            enter(LS_HANGUP);
            owe(C_NONE, 4'd0, 1'b1);
         end else begin
            tone = T_RINGBACK;
            enter(LS_OUTCALL);
            for (i = 0; i < dialled_count && i < DIAL_CAPACITY; i++)
               owe(C_DIAL, dialled[i], (i + 1 == dialled_count));
         end
      endfunction

      function void note_event(logic [1:0] kind, logic hook, logic [3:0] dig,
                               logic [1:0] ev);
         logic [1:0]     cmd;
         line_state_type st;
         cmd = C_NONE;
         st = state;
         case (kind)
            K_TICK: begin
               if (st == LS_DIALING) begin
                  if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
                  if (idle_ms >= digit_timeout_ms) begin
                     start_dial();
                     return;
                  end
               end else if (st == LS_HANGUP) begin
                  if (hangup_ms != 16'hFFFF) hangup_ms = hangup_ms + 16'd1;
                  if (hangup_ms >= hold_ms) begin
                     tone = T_NONE;
                     enter(LS_IDLE);
                     hangup_ms = '0;
                  end
               end else begin
                  hangup_ms = '0;
               end
            end
            K_HOOK: begin
               if (hook != hook_prev) begin
                  if (hook) begin
                     if (st == LS_IDLE) begin
                        tone = T_DIAL;
                        dialled_count = 0;
                        enter(LS_DIALTONE);
                     end else if (st == LS_RINGING) begin
                        ringer = 1'b0;
                        cmd = C_ANSWER;
                        tone = T_NONE;
                        enter(LS_INCALL);
                     end
                  end else begin
                     if (st == LS_INCALL || st == LS_OUTCALL) begin
                        cmd = C_HANGUP;
                        tone = T_NONE;
                        enter(LS_HANGUP);
                     end else if (st == LS_DIALTONE || st == LS_DIALING) begin
                        cmd = C_HANGUP;
                        tone = T_NONE;
                        enter(LS_IDLE);
                     end else if (st == LS_HANGUP) begin
                        tone = T_NONE;
                        enter(LS_IDLE);
                     end
                  end
                  hook_prev = hook;
               end
            end
            K_DIGIT: begin
               if (st == LS_DIALTONE) begin
                  // the first digit is stored whatever it is, pound included
                  tone = T_NONE;
                  dialled[0] = dig;
                  dialled_count = 1;
                  idle_ms = '0;
                  enter(LS_DIALING);
               end else if (st == LS_DIALING) begin
                  if (dig == POUND_CODE) begin
                     start_dial();
                     return;
                  end
                  // digits beyond capacity are dropped
                  if (dialled_count < DIAL_CAPACITY) begin
                     dialled[dialled_count] = dig;
                     dialled_count++;
                     idle_ms = '0;
                  end
               end
            end
            default: begin
               case (ev)
                  ME_RING: begin
                     if (st == LS_IDLE) begin
                        ringer = 1'b1;
                        enter(LS_RINGING);
                     end
                  end
                  ME_ENDED: begin
                     if (st == LS_RINGING) begin
                        ringer = 1'b0;
                        enter(LS_IDLE);
                     end else if (st == LS_INCALL || st == LS_OUTCALL) begin
                        tone = T_BUSY;
                        enter(LS_HANGUP);
                     end else if (st == LS_DIALING) begin
                        tone = T_CONGESTION;
                        enter(LS_HANGUP);
                     end else begin
                        enter(LS_IDLE);
                     end
                  end
                  ME_CONNECTED: begin
                     if (st == LS_OUTCALL) tone = T_NONE;
                  end
                  default: ;
               endcase
            end
         endcase
         owe(cmd, 4'd0, 1'b1);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(line_report_type got);
         line_report_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         compare_field("ring_active", want.ring, got.ring);
         compare_field("tone_select", want.tone, got.tone);
         compare_field("modem_command", want.cmd, got.cmd);
         compare_field("dial_digit", want.digit, got.digit);
         compare_field("line_state", want.state, got.state);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   bit                    clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_kind;
   logic                  req_hook_level;
   logic [DIGIT_W-1:0]    req_digit_code;
   logic [1:0]            req_modem_event;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_ring_active;
   logic [TONE_W-1:0]     rsp_tone_select;
   logic [CMD_W-1:0]      rsp_modem_command;
   logic [DIGIT_W-1:0]    rsp_dial_digit;
   logic [2:0]            rsp_line_state;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   line_scoreboard  sb;
   line_report_type seen_report;
   int              cycle_count;
   int              sent_items;
   int              no_gap_left;
   logic            hook_now;
   logic            long_hold_ask;
   int              cur_idt;
   int              cur_hold;
   int              cur_min;

   // register settings per phase, extremes included
   int phase_idt[PHASES]  = '{3, 1, 65535, 8, 20};
   int phase_hold[PHASES] = '{2, 1, 65535, 5, 12};
   int phase_min[PHASES]  = '{1, 31, 3, 4, 2};

   phone_line_call_control_fsm #(
      .DIGIT_STORE_DEPTH(STORE_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_hook_level    (req_hook_level),
      .req_digit_code    (req_digit_code),
      .req_modem_event   (req_modem_event),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ring_active   (rsp_ring_active),
      .rsp_tone_select   (rsp_tone_select),
      .rsp_modem_command (rsp_modem_command),
      .rsp_dial_digit    (rsp_dial_digit),
      .rsp_line_state    (rsp_line_state),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // monitor: note accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_event(req_kind, req_hook_level, req_digit_code, req_modem_event);
         if (rsp_valid && !rsp_stall) begin
            seen_report.ring = rsp_ring_active;
            seen_report.tone = rsp_tone_select;
            seen_report.cmd = rsp_modem_command;
            seen_report.digit = rsp_dial_digit;
            seen_report.state = rsp_line_state;
            seen_report.last = rsp_last;
            sb.check_response(seen_report);
         end
      end
   end

   // response side back-pressure, with one long hold-off on request
   initial begin
      int span;
      int pick;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_ask) begin
            long_hold_ask = 1'b0;
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_stall = 1'b0;
               span = $urandom_range(1, 20);
            end else if (pick < 93) begin
               rsp_stall = 1'b1;
               span = $urandom_range(1, 3);
            end else begin
               rsp_stall = 1'b1;
               span = $urandom_range(8, 40);
            end
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   // one request transaction, held until accepted; entered and left at negedge
   task automatic send_event(input logic [1:0] kind, input logic hook,
                             input logic [3:0] dig, input logic [1:0] ev);
      int gap;
      int pick;
      if (no_gap_left > 0) begin
         gap = 0;
         no_gap_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3) no_gap_left = $urandom_range(10, 30);
         if (pick < 70) gap = 0;
         else if (pick < 95) gap = $urandom_range(1, 3);
         else gap = $urandom_range(5, 30);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind = kind;
      req_hook_level = hook;
      req_digit_code = dig;
      req_modem_event = ev;
      req_valid = 1'b1;
      if (kind == K_HOOK) hook_now = hook;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_items++;
   endtask

   // unused fields carry random values
   task automatic send_tick();
      send_event(K_TICK, $urandom, $urandom, $urandom);
   endtask

   task automatic send_hook(input logic hook);
      send_event(K_HOOK, hook, $urandom, $urandom);
   endtask

   task automatic send_digit(input logic [3:0] dig);
      send_event(K_DIGIT, $urandom, dig, $urandom);
   endtask

   task automatic send_modem(input logic [1:0] ev);
      send_event(K_MODEM, $urandom, $urandom, ev);
   endtask

   // sender holds off until every owed response has arrived
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_index = idx;
      csr_data = value[15:0];
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, value[15:0]);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // two call-ended events reach idle from any state
   task automatic go_idle();
      if (hook_now) send_hook(1'b0);
      send_modem(ME_ENDED);
      send_modem(ME_ENDED);
   endtask

   task automatic leave_hangup();
      if (cur_hold <= 30 && $urandom_range(0, 1)) begin
         repeat (cur_hold + $urandom_range(0, 2)) send_tick();
      end else if (hook_now) begin
         send_hook(1'b0);
      end else begin
         send_modem(ME_ENDED);
      end
   endtask

   task automatic outgoing_call(input int n);
      int         i;
      logic [3:0] dig;
      if ($urandom_range(0, 4) != 0) go_idle();
      send_hook(1'b1);
      send_digit($urandom_range(0, 15));
      for (i = 1; i < n; i++) begin
         // any code but the pound key
         dig = $urandom_range(0, 14);
         if (dig >= POUND_CODE) dig = dig + 4'd1;
         send_digit(dig);
         if (i < n - 1 && cur_idt >= 2 && $urandom_range(0, 4) == 0) send_tick();
      end
      // dial on the inter-digit timeout or the pound key
      if (cur_idt <= 40 && $urandom_range(0, 1)) repeat (cur_idt) send_tick();
      else send_digit(POUND_CODE);
      if (((n < DIAL_CAPACITY) ? n : DIAL_CAPACITY) >= cur_min) begin
         if ($urandom_range(0, 1)) send_modem(ME_CONNECTED);
         repeat ($urandom_range(0, 3)) send_tick();
         if ($urandom_range(0, 1)) send_hook(1'b0);
         else send_modem(ME_ENDED);
      end
      leave_hangup();
   endtask

   task automatic incoming_call();
      if ($urandom_range(0, 4) != 0) go_idle();
      send_modem(ME_RING);
      repeat ($urandom_range(0, 3)) send_tick();
      if ($urandom_range(0, 9) < 7) begin
         send_hook(1'b1);
         repeat ($urandom_range(0, 3)) send_tick();
         if ($urandom_range(0, 1)) send_hook(1'b0);
         else send_modem(ME_ENDED);
         leave_hangup();
      end else begin
         send_modem(ME_ENDED);
      end
   endtask

   // stimulus
   initial begin
      int ph;
      int pick;
      int n;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = K_TICK;
      req_hook_level = 1'b0;
      req_digit_code = '0;
      req_modem_event = ME_RING;
      csr_valid = 1'b0;
      csr_index = CSR_INTER_DIGIT;
      csr_data = '0;
      hook_now = 1'b0;
      long_hold_ask = 1'b0;
      sent_items = 0;
      no_gap_left = 0;
      cur_idt = INTER_DIGIT_RESET;
      cur_hold = HANGUP_HOLD_RESET;
      cur_min = MIN_DIGITS_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part under reset settings
      send_tick();
      send_modem(ME_RESERVED);
      send_modem(ME_CONNECTED);
      send_hook(1'b0);
      send_digit(4'd15);
      send_modem(ME_RING);
      send_modem(ME_RING);
      send_hook(1'b1);
      send_hook(1'b1);
      send_hook(1'b0);
      send_modem(ME_ENDED);
      send_hook(1'b1);
      send_digit(POUND_CODE);
      send_digit(4'd0);
      send_digit(4'd15);
      send_digit(POUND_CODE);
      send_modem(ME_CONNECTED);
      send_modem(ME_ENDED);
      send_hook(1'b0);
      send_hook(1'b1);
      send_digit(4'd5);
      send_digit(POUND_CODE);
      send_tick();
      send_modem(ME_ENDED);

      // random calls under each register setting
      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         repeat (12) @(negedge clock);
         cur_idt = phase_idt[ph];
         cur_hold = phase_hold[ph];
         cur_min = phase_min[ph];
         write_reg(CSR_INTER_DIGIT, cur_idt);
         write_reg(CSR_HANGUP_HOLD, cur_hold);
         write_reg(CSR_MIN_DIGITS, cur_min);
         sent_items = 0;
         if (ph == 2) begin
            // long receiver hold-off against a full-length dial
            long_hold_ask = 1'b1;
            outgoing_call(DIAL_CAPACITY);
         end
         while (sent_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               n = $urandom_range(0, 99);
               if (n < 70) n = $urandom_range(1, 6);
               else if (n < 88) n = $urandom_range(7, 20);
               else n = $urandom_range(28, 34);
               if (cur_min > 10 && $urandom_range(0, 1)) n = $urandom_range(29, 33);
               outgoing_call(n);
            end else if (pick < 75) begin
               incoming_call();
            end else if (pick < 88) begin
               repeat ($urandom_range(1, 6))
                  send_event($urandom_range(0, 3), $urandom, $urandom, $urandom);
            end else if (pick < 94) begin
               // abandoned dial: lift, maybe a digit, replace
               go_idle();
               send_hook(1'b1);
               if ($urandom_range(0, 1)) send_digit($urandom_range(0, 15));
               if ($urandom_range(0, 1)) send_hook(1'b0);
               else send_modem(ME_ENDED);
            end else begin
               wait_drained();
            end
         end
      end

      // drain and settle
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
